/* rtl/core/thi_pkg.sv */
// Package for the tile height interpolator.
// Holds the tile constants, field widths and the stage payload structs.
// Depends on nothing; every core file refers to it by scoped names.
package thi_pkg;

    localparam int TILE_EDGE  = 64;
    localparam int HALF_EDGE  = TILE_EDGE / 2;
    localparam int HALF_SHIFT = $clog2(HALF_EDGE);
    localparam int POS_W      = 6;
    localparam int HGT_W      = 15;
    localparam int HGT_MAX    = 32767;
    // Magnitude of (b - a) * px stays below 2^(HGT_W + POS_W)
    localparam int NUM_W      = HGT_W + POS_W;

    // Triangle chosen for the point, mirrored into the standard triangle
    typedef struct packed {
        logic [HGT_W-1:0] side;
        logic [HGT_W-1:0] corner;
        logic [HGT_W-1:0] center;
        logic [POS_W-1:0] px;
        logic [POS_W-1:0] pz;
    } t_tri;

    // Heights on the two triangle sides at depth pz
    typedef struct packed {
        logic signed [HGT_W+1:0] a;
        logic signed [HGT_W+1:0] b;
        logic [POS_W-1:0]        px;
        logic [POS_W-1:0]        span;
        logic                    hit;
        logic [HGT_W-1:0]        corner;
    } t_ab;

    // Word that walks down the divider chain
    typedef struct packed {
        logic [POS_W-2:0]        rem;
        logic [NUM_W-1:0]        num;
        logic [NUM_W-1:0]        quo;
        logic [POS_W-1:0]        span;
        logic                    neg;
        logic signed [HGT_W+1:0] a;
        logic                    hit;
        logic [HGT_W-1:0]        corner;
    } t_div;

endpackage

/* rtl/core/thi_tri_sel.sv */
// Triangle selection stage: picks one of the eight fan triangles and
// mirrors the point into the standard triangle. Uses thi_pkg.
module thi_tri_sel (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_vld,
    output logic                       o_rdy,
    input  logic [thi_pkg::POS_W-1:0]  i_x,
    input  logic [thi_pkg::POS_W-1:0]  i_z,
    input  logic [thi_pkg::HGT_W-1:0]  i_bl,
    input  logic [thi_pkg::HGT_W-1:0]  i_tl,
    input  logic [thi_pkg::HGT_W-1:0]  i_tr,
    input  logic [thi_pkg::HGT_W-1:0]  i_br,
    input  logic [thi_pkg::HGT_W-1:0]  i_ce,
    output logic                       o_vld,
    input  logic                       i_rdy,
    output thi_pkg::t_tri              o_tri
);

    localparam logic [thi_pkg::POS_W:0] T7 = (thi_pkg::POS_W+1)'(thi_pkg::TILE_EDGE);
    localparam logic [thi_pkg::POS_W:0] H7 = (thi_pkg::POS_W+1)'(thi_pkg::HALF_EDGE);

    logic                       r_vld;
    thi_pkg::t_tri              r_tri;
    thi_pkg::t_tri              n_tri;
    logic [thi_pkg::POS_W:0]    x7, z7, zr;
    logic [thi_pkg::HGT_W:0]    s_lft, s_top, s_rgt, s_bot;
    logic [thi_pkg::POS_W:0]    px7, pz7;

    // Edge midpoints and quadrant decode
    always_comb begin
        x7    = {1'b0, i_x};
        z7    = {1'b0, i_z};
        zr    = T7 - z7;
        s_lft = {1'b0, i_bl} + {1'b0, i_tl};
        s_top = {1'b0, i_tl} + {1'b0, i_tr};
        s_rgt = {1'b0, i_br} + {1'b0, i_tr};
        s_bot = {1'b0, i_bl} + {1'b0, i_br};
        n_tri.center = i_ce;
        if (zr >= H7) begin
            if (x7 < H7) begin
                n_tri.corner = i_tl;
                if (z7 > x7) begin
                    n_tri.side = s_lft[thi_pkg::HGT_W:1];
                    px7 = x7;  pz7 = zr - H7;
                end else begin
                    n_tri.side = s_top[thi_pkg::HGT_W:1];
                    px7 = z7;  pz7 = H7 - x7;
                end
            end else begin
                n_tri.corner = i_tr;
                if (zr > x7) begin
                    n_tri.side = s_top[thi_pkg::HGT_W:1];
                    px7 = z7;  pz7 = x7 - H7;
                end else begin
                    n_tri.side = s_rgt[thi_pkg::HGT_W:1];
                    px7 = T7 - x7;  pz7 = zr - H7;
                end
            end
        end else if (x7 < H7) begin
            n_tri.corner = i_bl;
            if (zr > x7) begin
                n_tri.side = s_lft[thi_pkg::HGT_W:1];
                px7 = x7;  pz7 = H7 - zr;
            end else begin
                n_tri.side = s_bot[thi_pkg::HGT_W:1];
                px7 = zr;  pz7 = H7 - x7;
            end
        end else begin
            n_tri.corner = i_br;
            if (z7 > x7) begin
                n_tri.side = s_bot[thi_pkg::HGT_W:1];
                px7 = zr;  pz7 = x7 - H7;
            end else begin
                n_tri.side = s_rgt[thi_pkg::HGT_W:1];
                px7 = T7 - x7;  pz7 = H7 - zr;
            end
        end
        n_tri.px = px7[thi_pkg::POS_W-1:0];
        n_tri.pz = pz7[thi_pkg::POS_W-1:0];
    end

    assign o_rdy = !r_vld || i_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
        if (o_rdy && i_vld) begin
            r_tri <= n_tri;
        end
    end

    assign o_vld = r_vld;
    assign o_tri = r_tri;

endmodule

/* rtl/core/thi_edge_interp.sv */
// Side interpolation stage: heights a and b on the two triangle sides
// at depth pz, truncating division by the half edge. Uses thi_pkg.
module thi_edge_interp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    output logic          o_rdy,
    input  thi_pkg::t_tri i_tri,
    output logic          o_vld,
    input  logic          i_rdy,
    output thi_pkg::t_ab  o_ab
);

    localparam int PW = thi_pkg::HGT_W + thi_pkg::POS_W + 1;

    logic                          r_vld;
    thi_pkg::t_ab                  r_ab;
    thi_pkg::t_ab                  n_ab;
    logic signed [thi_pkg::HGT_W:0] d1, d2;
    logic signed [PW-1:0]          m1, m2, t1, t2;
    logic signed [thi_pkg::POS_W:0] pz_s;

    // a = trunc((corner - side) * pz / H) + side, b likewise from center
    always_comb begin
        pz_s = $signed({1'b0, i_tri.pz});
        d1   = $signed({1'b0, i_tri.corner}) - $signed({1'b0, i_tri.side});
        d2   = $signed({1'b0, i_tri.corner}) - $signed({1'b0, i_tri.center});
        m1   = PW'(d1 * pz_s);
        m2   = PW'(d2 * pz_s);
        // bias negatives so the arithmetic shift truncates toward zero
        t1   = m1 + (m1[PW-1] ? PW'(thi_pkg::HALF_EDGE - 1) : PW'(0));
        t2   = m2 + (m2[PW-1] ? PW'(thi_pkg::HALF_EDGE - 1) : PW'(0));
        n_ab.a = (thi_pkg::HGT_W+2)'(t1 >>> thi_pkg::HALF_SHIFT)
               + $signed({2'b00, i_tri.side});
        n_ab.b = (thi_pkg::HGT_W+2)'(t2 >>> thi_pkg::HALF_SHIFT)
               + $signed({2'b00, i_tri.center});
        n_ab.px     = i_tri.px;
        n_ab.span   = thi_pkg::POS_W'(thi_pkg::HALF_EDGE) - i_tri.pz;
        n_ab.hit    = (i_tri.pz == thi_pkg::POS_W'(thi_pkg::HALF_EDGE));
        n_ab.corner = i_tri.corner;
    end

    assign o_rdy = !r_vld || i_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
        if (o_rdy && i_vld) begin
            r_ab <= n_ab;
        end
    end

    assign o_vld = r_vld;
    assign o_ab  = r_ab;

endmodule

/* rtl/core/thi_num.sv */
// Numerator stage: (b - a) * px split into sign and magnitude, forming
// the word that enters the divider chain. Uses thi_pkg.
module thi_num (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    output logic          o_rdy,
    input  thi_pkg::t_ab  i_ab,
    output logic          o_vld,
    input  logic          i_rdy,
    output thi_pkg::t_div o_div
);

    localparam int PW = thi_pkg::HGT_W + thi_pkg::POS_W + 4;

    logic                            r_vld;
    thi_pkg::t_div                   r_div;
    thi_pkg::t_div                   n_div;
    logic signed [thi_pkg::HGT_W+2:0] diff;
    logic signed [PW-1:0]            prod;
    logic [PW-1:0]                   mag;

    always_comb begin
        diff = (thi_pkg::HGT_W+3)'(i_ab.b) - (thi_pkg::HGT_W+3)'(i_ab.a);
        prod = PW'(diff * $signed({1'b0, i_ab.px}));
        mag  = prod[PW-1] ? PW'(-prod) : PW'(prod);
        n_div.rem    = '0;
        n_div.num    = mag[thi_pkg::NUM_W-1:0];
        n_div.quo    = '0;
        n_div.span   = i_ab.span;
        n_div.neg    = prod[PW-1];
        n_div.a      = i_ab.a;
        n_div.hit    = i_ab.hit;
        n_div.corner = i_ab.corner;
    end

    assign o_rdy = !r_vld || i_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
        if (o_rdy && i_vld) begin
            r_div <= n_div;
        end
    end

    assign o_vld = r_vld;
    assign o_div = r_div;

endmodule

/* rtl/core/thi_div_cell.sv */
// One restoring-division cell: takes the next numerator bit, retires one
// quotient bit and passes the word to its neighbor. Uses thi_pkg.
module thi_div_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    output logic          o_rdy,
    input  thi_pkg::t_div i_div,
    output logic          o_vld,
    input  logic          i_rdy,
    output thi_pkg::t_div o_div
);

    logic                      r_vld;
    thi_pkg::t_div             r_div;
    thi_pkg::t_div             n_div;
    logic [thi_pkg::POS_W-1:0] trial;
    logic [thi_pkg::POS_W-1:0] diff;
    logic                      qbit;

    // Shift in one bit, subtract the divisor when it fits
    always_comb begin
        trial = {i_div.rem, i_div.num[thi_pkg::NUM_W-1]};
        diff  = trial - i_div.span;
        qbit  = (trial >= i_div.span);
        n_div     = i_div;
        n_div.rem = qbit ? diff[thi_pkg::POS_W-2:0] : trial[thi_pkg::POS_W-2:0];
        n_div.num = {i_div.num[thi_pkg::NUM_W-2:0], 1'b0};
        n_div.quo = {i_div.quo[thi_pkg::NUM_W-2:0], qbit};
    end

    assign o_rdy = !r_vld || i_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
        if (o_rdy && i_vld) begin
            r_div <= n_div;
        end
    end

    assign o_vld = r_vld;
    assign o_div = r_div;

endmodule

/* rtl/core/tile_height_interpolator_top.sv */
// Top level of the tile height interpolator.
// Depends on thi_pkg, thi_tri_sel, thi_edge_interp, thi_num, thi_div_cell.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries a position inside one
//   tile plus the four corner heights and the center height. Output channel
//   (o_out_valid / i_out_ready) returns one surface height per transfer,
//   in input order.
//   With no stall, a result passes through triangle select, side interpolation,
//   numerator product, 21 divider cells (one quotient bit each) and the
//   output register. One item is taken every cycle while o_in_ready is high;
//   the row of divider cells sets the depth.
//   Every stage has its own valid bit and moves whenever the stage after it
//   is empty or moving, so bubbles close up and the input keeps taking
//   items while a finished result waits at the output.
//   When the receiver stalls, the result holds on the output ports and the
//   stages behind it fill; o_in_ready drops only once every stage is full.
//   Synchronous reset clears all valid bits; the pipeline is empty after it.
module tile_height_interpolator_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [thi_pkg::POS_W-1:0] i_offset_x,
    input  logic [thi_pkg::POS_W-1:0] i_offset_z,
    input  logic [thi_pkg::HGT_W-1:0] i_height_bl,
    input  logic [thi_pkg::HGT_W-1:0] i_height_tl,
    input  logic [thi_pkg::HGT_W-1:0] i_height_tr,
    input  logic [thi_pkg::HGT_W-1:0] i_height_br,
    input  logic [thi_pkg::HGT_W-1:0] i_height_center,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [thi_pkg::HGT_W-1:0] o_surface_height
);

    localparam int N = thi_pkg::NUM_W;
    localparam int RW = thi_pkg::NUM_W + 2;

    thi_pkg::t_tri            w_tri;
    thi_pkg::t_ab             w_ab;
    logic                     w_tri_vld, w_tri_rdy, w_ab_vld, w_ab_rdy;
    thi_pkg::t_div            w_div [N+1];
    logic [N:0]               w_vld;
    logic [N:0]               w_rdy;
    logic                     r_out_vld;
    logic [thi_pkg::HGT_W-1:0] r_out_h;
    logic [thi_pkg::HGT_W-1:0] n_out_h;
    logic                     out_rdy;
    logic signed [RW-1:0]     qs;
    logic signed [RW-1:0]     res;

    thi_tri_sel u_sel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_in_valid),
        .o_rdy   (o_in_ready),
        .i_x     (i_offset_x),
        .i_z     (i_offset_z),
        .i_bl    (i_height_bl),
        .i_tl    (i_height_tl),
        .i_tr    (i_height_tr),
        .i_br    (i_height_br),
        .i_ce    (i_height_center),
        .o_vld   (w_tri_vld),
        .i_rdy   (w_tri_rdy),
        .o_tri   (w_tri)
    );

    thi_edge_interp u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_tri_vld),
        .o_rdy   (w_tri_rdy),
        .i_tri   (w_tri),
        .o_vld   (w_ab_vld),
        .i_rdy   (w_ab_rdy),
        .o_ab    (w_ab)
    );

    thi_num u_num (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_ab_vld),
        .o_rdy   (w_ab_rdy),
        .i_ab    (w_ab),
        .o_vld   (w_vld[0]),
        .i_rdy   (w_rdy[0]),
        .o_div   (w_div[0])
    );

    // Divider row: one cell per quotient bit
    for (genvar k = 0; k < N; k++) begin : g_cell
        thi_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_vld[k]),
            .o_rdy   (w_rdy[k]),
            .i_div   (w_div[k]),
            .o_vld   (w_vld[k+1]),
            .i_rdy   (w_rdy[k+1]),
            .o_div   (w_div[k+1])
        );
    end

    // Signed quotient plus a, clamped; corner point bypasses the division
    always_comb begin
        qs  = $signed({2'b00, w_div[N].quo});
        res = (w_div[N].neg ? -qs : qs) + RW'(w_div[N].a);
        if (w_div[N].hit) begin
            n_out_h = w_div[N].corner;
        end else if (res < 0) begin
            n_out_h = '0;
        end else if (res > RW'(thi_pkg::HGT_MAX)) begin
            n_out_h = thi_pkg::HGT_W'(thi_pkg::HGT_MAX);
        end else begin
            n_out_h = res[thi_pkg::HGT_W-1:0];
        end
    end

    assign out_rdy  = !r_out_vld || i_out_ready;
    assign w_rdy[N] = out_rdy;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_rdy) begin
            r_out_vld <= w_vld[N];
        end
        if (out_rdy && w_vld[N]) begin
            r_out_h <= n_out_h;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_surface_height = r_out_h;

endmodule

/* rtl/core/thi_checker.sv */
// Port-level checker for the tile height interpolator, with its bind.
// Depends on thi_pkg and tile_height_interpolator_top.
module thi_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_in_ready,
    input logic                      o_out_valid,
    input logic                      i_out_ready,
    input logic [thi_pkg::HGT_W-1:0] o_surface_height
);

    // A stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_surface_height))
        else $error("output changed while stalled");

    // An empty output means the whole pipe can move, so input is open
    a_ready_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty output");

    // Reset empties the pipe
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // Ready only drops while the receiver holds back a result
    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_ready) |-> o_out_valid && !i_out_ready)
        else $error("input ready fell without output stall");

endmodule

bind tile_height_interpolator_top thi_checker u_thi_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_surface_height (o_surface_height)
);
